// ===== hdl/gws_pkg.sv =====
// Shared constants, types and helper functions for the grid word search block.
`timescale 1ns / 1ps

package gws_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int MAX_WORD  = 16;

  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int WIDX_W = 4;
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 5;
  localparam int DIR_W  = 3;
  localparam int ADDR_W = $clog2(GRID_ROWS * GRID_COLS);
  localparam int WADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LEN_W  = $clog2(MAX_WORD + 1);
  // Signed coordinate wide enough for -1 up to the grid size.
  localparam int COORD_W = $clog2(((GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS) + 1) + 1;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIR_W-1:0] DIR_LAST = 3'd7;

  typedef enum logic [1:0] {
    OP_GRID_WR = 2'd0,
    OP_WORD_WR = 2'd1,
    OP_QUERY   = 2'd2,
    OP_UNUSED  = 2'd3
  } gws_op_t;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_LEN  = 2'd2,
    REG_NONE = 2'd3
  } gws_reg_t;

  typedef enum logic [1:0] {
    KIND_GRID  = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_QUERY = 2'd2
  } gws_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SETUP,
    ST_READ,
    ST_CMP,
    ST_DONE
  } gws_state_t;

  typedef struct packed {
    gws_kind_t         kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [WIDX_W-1:0] widx;
    logic [CHAR_W-1:0] ch;
  } gws_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] len;
  } gws_cfg_t;

  function automatic logic signed [COORD_W-1:0] step_row(input logic [DIR_W-1:0] d);
    logic signed [COORD_W-1:0] s;
    case (d)
      3'd0, 3'd3, 3'd5: s = -COORD_W'(1);
      3'd2, 3'd4, 3'd7: s = COORD_W'(1);
      default:          s = '0;
    endcase
    return s;
  endfunction

  function automatic logic signed [COORD_W-1:0] step_col(input logic [DIR_W-1:0] d);
    logic signed [COORD_W-1:0] s;
    case (d)
      3'd0, 3'd1, 3'd2: s = -COORD_W'(1);
      3'd5, 3'd6, 3'd7: s = COORD_W'(1);
      default:          s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/grid_word_search_top.sv =====
// Top level of the grid word search block: configuration registers and the two halves.
`timescale 1ns / 1ps

// Grid word search. Requests load a 16 x 16 byte grid and a word of up to 16 bytes, or
// query a start cell; a query returns whether the word reads from that cell in one of
// eight directions, tried in fixed order, and the first direction that matches. A load
// is written when it is popped and gives no result. A query whose start cell does not
// match goes through the pop with the start cell read, the check and the result load.
// Otherwise each direction tried takes a setup step, a read and a compare step per
// character and one more read step when it stops at the grid edge or on a full match;
// the separate read and compare steps are set by the single read port of the grid
// memory and its registered read data. The result load waits while an earlier result
// is still held. A two-entry request queue lets new requests be taken while a search
// runs, and the result register lets the engine go on while a result waits.
// Configuration is taken in any cycle and must only be written while the block is idle.

module grid_word_search_top
  import gws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: row[3:0], col[7:4], word_index[11:8], char_value[19:12], zeros[23:20]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  // out_tdata: start_row[3:0], start_col[7:4], found[8], direction[11:9], zeros[15:12]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  gws_cfg_t  cfg_r, cfg_nxt;
  logic      q_valid;
  gws_item_t q_item;
  logic      q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (gws_reg_t'(cfg_index))
        REG_ROWS: cfg_nxt.rows = cfg_data;
        REG_COLS: cfg_nxt.cols = cfg_data;
        REG_LEN:  cfg_nxt.len  = cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows <= CFG_W'(16);
      cfg_r.cols <= CFG_W'(16);
      cfg_r.len  <= CFG_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  gws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hdl/gws_front.sv =====
// Front end: accepts input requests, decodes them and queues the useful ones.
`timescale 1ns / 1ps

module gws_front
  import gws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [IN_USER_W-1:0] in_tuser,
  output logic                 q_valid,
  output gws_item_t            q_item,
  input  logic                 q_pop
);

  gws_item_t   entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  gws_op_t     op;
  gws_item_t   item;
  logic        keep;
  logic        push;

  always_comb begin
    op        = gws_op_t'(in_tuser);
    item.row  = in_tdata[3:0];
    item.col  = in_tdata[7:4];
    item.widx = in_tdata[11:8];
    item.ch   = in_tdata[19:12];
    item.kind = KIND_QUERY;
    keep      = 1'b0;
    case (op)
      OP_GRID_WR: begin
        item.kind = KIND_GRID;
        keep = (32'(item.row) < GRID_ROWS) && (32'(item.col) < GRID_COLS);
      end
      OP_WORD_WR: begin
        item.kind = KIND_WORD;
        keep = 32'(item.widx) < MAX_WORD;
      end
      OP_QUERY: begin
        item.kind = KIND_QUERY;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== hdl/gws_back.sv =====
// Back end: grid and word stores, the search sequencer and the result register.
`timescale 1ns / 1ps

module gws_back
  import gws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  gws_cfg_t              cfg,
  input  logic                  q_valid,
  input  gws_item_t             q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [CHAR_W-1:0] grid_mem [GRID_ROWS*GRID_COLS];
  logic [CHAR_W-1:0] word_r [MAX_WORD];
  logic [CHAR_W-1:0] rd_data_r;

  gws_state_t                state_r, state_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [DIR_W-1:0]          dir_r, dir_nxt;
  logic signed [COORD_W-1:0] r_r, r_nxt;
  logic signed [COORD_W-1:0] c_r, c_nxt;
  logic [LEN_W-1:0]          j_r, j_nxt;
  logic                      found_r, found_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r, out_data_nxt;

  logic                      mem_we, mem_re, word_we;
  logic [ADDR_W-1:0]         mem_waddr, mem_raddr;

  logic [CFG_W-1:0]          nrows, ncols, len;
  logic                      start_in, step_in;
  logic [ADDR_W-1:0]         start_addr, step_addr;

  // Used sizes above the store act as the store size.
  always_comb begin
    nrows = (32'(cfg.rows) > GRID_ROWS) ? CFG_W'(GRID_ROWS) : cfg.rows;
    ncols = (32'(cfg.cols) > GRID_COLS) ? CFG_W'(GRID_COLS) : cfg.cols;
    len   = (32'(cfg.len)  > MAX_WORD)  ? CFG_W'(MAX_WORD)  : cfg.len;
  end

  always_comb begin
    start_in   = (CFG_W'(row_r) < nrows) && (CFG_W'(col_r) < ncols) && (len != '0);
    step_in    = !r_r[COORD_W-1] && !c_r[COORD_W-1] &&
                 (CFG_W'(r_r) < nrows) && (CFG_W'(c_r) < ncols);
    start_addr = ADDR_W'(row_r) * ADDR_W'(GRID_COLS) + ADDR_W'(col_r);
    step_addr  = ADDR_W'(r_r) * ADDR_W'(GRID_COLS) + ADDR_W'(c_r);
    mem_waddr  = ADDR_W'(q_item.row) * ADDR_W'(GRID_COLS) + ADDR_W'(q_item.col);
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    dir_nxt       = dir_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    j_nxt         = j_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = start_addr;
    word_we       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            KIND_GRID: mem_we = 1'b1;
            KIND_WORD: word_we = 1'b1;
            KIND_QUERY: begin
              row_nxt   = q_item.row;
              col_nxt   = q_item.col;
              mem_re    = 1'b1;
              mem_raddr = mem_waddr;
              state_nxt = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        dir_nxt = '0;
        if (start_in && rd_data_r == word_r[0]) begin
          state_nxt = ST_SETUP;
        end else begin
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_SETUP: begin
        r_nxt     = $signed(COORD_W'(row_r)) + step_row(dir_r);
        c_nxt     = $signed(COORD_W'(col_r)) + step_col(dir_r);
        j_nxt     = LEN_W'(1);
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (CFG_W'(j_r) == len) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (step_in) begin
          mem_re    = 1'b1;
          mem_raddr = step_addr;
          state_nxt = ST_CMP;
        end else if (dir_r == DIR_LAST) begin
          found_nxt = 1'b0;
          dir_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          dir_nxt   = dir_r + DIR_W'(1);
          state_nxt = ST_SETUP;
        end
      end
      ST_CMP: begin
        if (rd_data_r == word_r[j_r[WADDR_W-1:0]]) begin
          j_nxt     = j_r + LEN_W'(1);
          r_nxt     = r_r + step_row(dir_r);
          c_nxt     = c_r + step_col(dir_r);
          state_nxt = ST_READ;
        end else if (dir_r == DIR_LAST) begin
          found_nxt = 1'b0;
          dir_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          dir_nxt   = dir_r + DIR_W'(1);
          state_nxt = ST_SETUP;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, dir_r, found_r, col_r, row_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    dir_r      <= dir_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    j_r        <= j_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= q_item.ch;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_r[q_item.widx[WADDR_W-1:0]] <= q_item.ch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/gws_checker.sv =====
// Port-level checks on the grid word search results, bound to the top level.
`timescale 1ns / 1ps

module gws_checker
  import gws_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A miss always reports direction zero.
  a_miss_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[11:9] == 3'd0)
    else $error("not-found result with nonzero direction");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] == 4'd0)
    else $error("result padding bits set");

endmodule

bind grid_word_search_top gws_checker u_gws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/tb_grid_word_search_top.sv =====
// Self-checking testbench for grid_word_search_top: directed corners, then random traffic.
`timescale 1ns / 1ps

module tb_grid_word_search_top;
  import gws_pkg::*;

  localparam int     RANDOM_ITEMS = 1300;
  localparam int     DRAIN_CYCLES = 32;
  localparam longint CYCLE_LIMIT  = 4_000_000;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             found;
    logic [DIR_W-1:0] dir;
  } hit_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_data   = '0;

  // Mirror of the block's stores and registers.
  logic [CHAR_W-1:0] grid_mirror [GRID_ROWS*GRID_COLS];
  logic [CHAR_W-1:0] word_mirror [MAX_WORD];
  logic [CFG_W-1:0]  rows_used = 5'd16;
  logic [CFG_W-1:0]  cols_used = 5'd16;
  logic [CFG_W-1:0]  word_len  = 5'd1;

  hit_t   pending_hits [$];
  int     errors        = 0;
  longint cycles        = 0;
  int     items_sent    = 0;
  bit     source_steady = 1'b0;
  bit     sink_steady   = 1'b0;
  int     sink_wait     = 0;
  bit     alpha_wide    = 1'b1;
  logic [CHAR_W-1:0] alpha_base = 8'h41;
  int     alpha_span    = 1;

  always #10 clk = ~clk;

  grid_word_search_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int row_step(int d);
    case (d)
      0, 3, 5: return -1;
      2, 4, 7: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int col_step(int d);
    case (d)
      0, 1, 2: return -1;
      5, 6, 7: return 1;
      default: return 0;
    endcase
  endfunction

  // Expected answer to a query from the mirrored grid, word and registers.
  function automatic hit_t search_word(logic [ROW_W-1:0] r0, logic [COL_W-1:0] c0);
    hit_t h;
    int   nrows, ncols, len, r, c, j, dr, dc;
    nrows   = (rows_used > GRID_ROWS) ? GRID_ROWS : int'(rows_used);
    ncols   = (cols_used > GRID_COLS) ? GRID_COLS : int'(cols_used);
    len     = (word_len > MAX_WORD) ? MAX_WORD : int'(word_len);
    h.row   = r0;
    h.col   = c0;
    h.found = 1'b0;
    h.dir   = '0;
    if (int'(r0) < nrows && int'(c0) < ncols && len > 0 &&
        grid_mirror[int'(r0)*GRID_COLS + int'(c0)] == word_mirror[0]) begin
      for (int d = 0; d < 8 && !h.found; d++) begin
        dr = row_step(d);
        dc = col_step(d);
        r  = int'(r0) + dr;
        c  = int'(c0) + dc;
        for (j = 1; j < len; j++) begin
          if (r < 0 || r >= nrows || c < 0 || c >= ncols) break;
          if (grid_mirror[r*GRID_COLS + c] != word_mirror[j]) break;
          r += dr;
          c += dc;
        end
        if (j == len) begin
          h.found = 1'b1;
          h.dir   = DIR_W'(d);
        end
      end
    end
    return h;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    if (alpha_wide) return CHAR_W'($urandom);
    return alpha_base + CHAR_W'($urandom_range(alpha_span));
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 5)  return 5'd0;
    if (p < 10) return 5'd1;
    if (p < 15) return CFG_W'($urandom_range(31, 17));
    if (p < 35) return 5'd16;
    return CFG_W'($urandom_range(15, 2));
  endfunction

  function automatic logic [CFG_W-1:0] pick_length();
    int p;
    p = $urandom_range(99);
    if (p < 5)  return 5'd0;
    if (p < 10) return CFG_W'($urandom_range(31, 17));
    if (p < 20) return 5'd16;
    return CFG_W'($urandom_range(6, 1));
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input gws_op_t op, input logic [ROW_W-1:0] r,
                              input logic [COL_W-1:0] c, input logic [WIDX_W-1:0] wi,
                              input logic [CHAR_W-1:0] ch);
    int gap;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, ch, wi, c, r};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    case (op)
      OP_GRID_WR: grid_mirror[int'(r)*GRID_COLS + int'(c)] = ch;
      OP_WORD_WR: word_mirror[wi] = ch;
      OP_QUERY:   pending_hits.push_back(search_word(r, c));
      default: ;
    endcase
  endtask

  task automatic write_cell(int r, int c, logic [CHAR_W-1:0] ch);
    send_request(OP_GRID_WR, ROW_W'(r), COL_W'(c), WIDX_W'($urandom), ch);
  endtask

  task automatic write_letter(int idx, logic [CHAR_W-1:0] ch);
    send_request(OP_WORD_WR, ROW_W'($urandom), COL_W'($urandom), WIDX_W'(idx), ch);
  endtask

  task automatic query_cell(int r, int c);
    send_request(OP_QUERY, ROW_W'(r), COL_W'(c), WIDX_W'($urandom), CHAR_W'($urandom));
  endtask

  task automatic write_reg(gws_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROWS: rows_used = val;
      REG_COLS: cols_used = val;
      REG_LEN:  word_len  = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every pending result, then let trailing loads drain out of the queue.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Lays the current word into the grid along one direction and queries its start.
  task automatic plant_word(int r0, int c0, int d, bit new_letters);
    int len, r, c;
    len = (word_len > MAX_WORD) ? MAX_WORD : int'(word_len);
    if (new_letters) begin
      for (int j = 0; j < len; j++) write_letter(j, pick_char());
    end
    r = r0;
    c = c0;
    for (int j = 0; j < len; j++) begin
      if (r >= 0 && r < GRID_ROWS && c >= 0 && c < GRID_COLS) write_cell(r, c, word_mirror[j]);
      r += row_step(d);
      c += col_step(d);
    end
    query_cell(r0, c0);
  endtask

  // Every cell and letter gets a value before any query can read it.
  task automatic fill_stores();
    for (int i = 0; i < GRID_ROWS*GRID_COLS; i++)
      write_cell(i / GRID_COLS, i % GRID_COLS, CHAR_W'($urandom));
    for (int i = 0; i < MAX_WORD; i++) write_letter(i, CHAR_W'($urandom));
  endtask

  task automatic test_directed_search();
    write_letter(0, 8'h00);
    write_cell(0, 0, 8'h00);
    query_cell(0, 0);
    write_letter(0, 8'hFF);
    write_cell(15, 15, 8'hFF);
    query_cell(15, 15);
    settle();
    write_reg(REG_LEN, 5'd2);
    // A fresh second letter per direction keeps earlier plants from matching first.
    write_letter(0, 8'hA5);
    write_cell(8, 8, 8'hA5);
    for (int d = 0; d < 8; d++) begin
      write_letter(1, 8'h50 + CHAR_W'(d));
      write_cell(8 + row_step(d), 8 + col_step(d), 8'h50 + CHAR_W'(d));
      query_cell(8, 8);
    end
  endtask

  task automatic test_register_corners();
    settle();
    write_reg(REG_ROWS, 5'd0);
    query_cell(8, 8);
    query_cell(0, 0);
    settle();
    write_reg(REG_ROWS, 5'd31);
    write_reg(REG_COLS, 5'd0);
    query_cell(0, 0);
    settle();
    write_reg(REG_COLS, 5'd17);
    query_cell(15, 15);
    query_cell(8, 8);
    settle();
    write_reg(REG_ROWS, 5'd4);
    write_reg(REG_COLS, 5'd4);
    query_cell(5, 2);
    query_cell(2, 5);
    query_cell(3, 3);
    settle();
    write_reg(REG_ROWS, 5'd16);
    write_reg(REG_COLS, 5'd16);
    write_reg(REG_LEN, 5'd0);
    query_cell(8, 8);
    settle();
    // Length above the word store acts as a full-length word along the diagonal.
    write_reg(REG_LEN, 5'd31);
    alpha_wide = 1'b1;
    plant_word(0, 0, 7, 1'b1);
    settle();
    write_reg(REG_NONE, 5'h1F);
    send_request(OP_UNUSED, ROW_W'($urandom), COL_W'($urandom), WIDX_W'($urandom),
                 CHAR_W'($urandom));
    query_cell(0, 0);
  endtask

  task automatic test_random_traffic();
    int stop_at, used_r, used_c, action, r, c;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      settle();
      source_steady = ($urandom_range(3) == 0);
      sink_steady   = ($urandom_range(3) == 0);
      alpha_wide    = ($urandom_range(4) == 0);
      alpha_base    = CHAR_W'($urandom);
      alpha_span    = $urandom_range(2, 1);
      write_reg(REG_ROWS, pick_size());
      write_reg(REG_COLS, pick_size());
      write_reg(REG_LEN, pick_length());
      if ($urandom_range(7) == 0) write_reg(REG_NONE, CFG_W'($urandom));
      used_r = (rows_used > GRID_ROWS) ? GRID_ROWS : int'(rows_used);
      used_c = (cols_used > GRID_COLS) ? GRID_COLS : int'(cols_used);
      repeat (60) begin
        action = $urandom_range(99);
        r = (used_r > 0) ? $urandom_range(used_r - 1) : $urandom_range(GRID_ROWS - 1);
        c = (used_c > 0) ? $urandom_range(used_c - 1) : $urandom_range(GRID_COLS - 1);
        if (action < 35) begin
          plant_word(r, c, $urandom_range(7), $urandom_range(1));
        end else if (action < 60) begin
          if ($urandom_range(9) == 0) query_cell($urandom_range(15), $urandom_range(15));
          else query_cell(r, c);
        end else if (action < 85) begin
          write_cell(r, c, pick_char());
        end else if (action < 95) begin
          write_letter($urandom_range(MAX_WORD - 1), pick_char());
        end else begin
          send_request(OP_UNUSED, ROW_W'($urandom), COL_W'($urandom), WIDX_W'($urandom),
                       CHAR_W'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (sink_wait > 0) begin
      out_tready <= 1'b0;
      sink_wait  <= sink_wait - 1;
    end else begin
      out_tready <= 1'b1;
      if (!sink_steady) sink_wait <= pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    hit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        $error("result with no query pending: out_tdata=%h", out_tdata);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (out_tdata[3:0] !== want.row) begin
          $error("start_row: expected %0d, got %0d", want.row, out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[7:4] !== want.col) begin
          $error("start_col: expected %0d, got %0d", want.col, out_tdata[7:4]);
          errors++;
        end
        if (out_tdata[8] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tdata[8]);
          errors++;
        end
        if (out_tdata[11:9] !== want.dir) begin
          $error("direction: expected %0d, got %0d", want.dir, out_tdata[11:9]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_grid_word_search_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    fill_stores();
    test_directed_search();
    test_register_corners();
    test_random_traffic();
    settle();
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("tb_grid_word_search_top: clean");
    end else begin
      $display("tb_grid_word_search_top: errors");
    end
    $finish;
  end

endmodule
